/* rtl/lst_pkg.sv */
// Shared types, constants and state codes for the segment tree range-add and search unit.
package lst_pkg;

   localparam int POSITIONS   = 1024;
   localparam int TREE_LEVELS = $clog2(POSITIONS);
   localparam int NODES       = 2 * POSITIONS;
   localparam int POS_W       = TREE_LEVELS;
   localparam int NODE_W      = $clog2(NODES);
   localparam int LVL_W       = $clog2(TREE_LEVELS + 1);
   localparam int CNT_W       = POS_W + 1;
   localparam int SUM_W       = 48;
   localparam int ADD_W       = 32;
   localparam int RANK_W      = 47;
   // remaining rank may drift by one subtree total per level
   localparam int KEY_W       = SUM_W + $clog2(TREE_LEVELS + 1) + 1;
   localparam int OP_W        = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 2'd0,
      OP_FIRST = 2'd1,
      OP_RANK  = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_ADD_LEFT,
      ST_Q_ROOT,
      ST_Q_ROOT_D,
      ST_Q_LEFT,
      ST_Q_LEFT_D,
      ST_Q_RIGHT_D,
      ST_Q_DONE
   } state_type;

   // one tree node: subtree total of adds applied at or below, and the node's own tag
   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] tag;
   } node_type;

   typedef struct packed {
      logic              rd_en;
      logic [NODE_W-1:0] rd_addr;
      logic              wr_en;
      logic [NODE_W-1:0] wr_addr;
      node_type          wr_data;
   } ram_req_type;

   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] position;
      logic             not_found;
   } result_type;

   typedef struct packed {
      logic busy;
      logic clearing;
   } status_type;

endpackage

/* rtl/lst_if.sv */
// Request and response channel interfaces.
interface lst_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         opcode;
   logic [lst_pkg::POS_W-1:0]          range_low;
   logic [lst_pkg::POS_W-1:0]          range_high;
   logic signed [lst_pkg::ADD_W-1:0]   add_value;
   logic [lst_pkg::RANK_W-1:0]         rank;

   modport source (output valid, opcode, range_low, range_high, add_value, rank,
                   input ready);
   modport sink   (input valid, opcode, range_low, range_high, add_value, rank,
                   output ready);
endinterface

interface lst_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lst_pkg::POS_W-1:0] position;
   logic                      not_found;

   modport source (output valid, position, not_found, input ready);
   modport sink   (input valid, position, not_found, output ready);
endinterface

/* rtl/lst_node_ram.sv */
// Node store: one write port, one read port with registered read data.
module lst_node_ram (
   input  logic                 clock,
   input  lst_pkg::ram_req_type ram_req,
   output lst_pkg::node_type    rd_data
);

   lst_pkg::node_type mem [lst_pkg::NODES];
   lst_pkg::node_type rd_data_ff;

   // write beat
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lst_walker.sv */
// Sequencer and shared datapath that walk the tree one level at a time.
module lst_walker (
   input  logic                 clock,
   input  logic                 reset,
   lst_req_if.sink              req,
   input  logic                 out_free,
   input  lst_pkg::node_type    rd_data,
   output lst_pkg::ram_req_type ram_req,
   output lst_pkg::result_type  result,
   output lst_pkg::status_type  status
);

   localparam int SX_W = lst_pkg::KEY_W - lst_pkg::SUM_W;

   lst_pkg::state_type             state_ff, state_in;
   logic [lst_pkg::NODE_W-1:0]     u_ff, u_in;
   logic [lst_pkg::POS_W-1:0]      a_ff, a_in;
   logic [lst_pkg::LVL_W-1:0]      lvl_ff, lvl_in;
   logic [lst_pkg::SUM_W-1:0]      acc_ff, acc_in;
   logic [lst_pkg::SUM_W-1:0]      tu_ff, tu_in;
   logic [lst_pkg::SUM_W-1:0]      cs_ff, cs_in;
   logic signed [lst_pkg::KEY_W-1:0] k_ff, k_in;
   logic [lst_pkg::OP_W-1:0]       op_ff, op_in;
   logic [lst_pkg::POS_W-1:0]      p_ff, p_in;
   logic [lst_pkg::POS_W-1:0]      lo_ff, lo_in;
   logic [lst_pkg::SUM_W-1:0]      v_ff, v_in;
   logic                           pass_ff, pass_in;
   logic [lst_pkg::SUM_W-1:0]      prod_ff, prod_in;
   logic [lst_pkg::NODE_W-1:0]     clr_ff, clr_in;

   logic [lst_pkg::NODE_W-1:0]     half;
   logic [lst_pkg::NODE_W-1:0]     span;
   logic [lst_pkg::POS_W-1:0]      p_off;
   logic [lst_pkg::CNT_W-1:0]      cnt;
   logic [lst_pkg::SUM_W+lst_pkg::CNT_W-1:0] prod_full;
   logic [lst_pkg::SUM_W-1:0]      acc_tu;
   logic [lst_pkg::SUM_W-1:0]      lt;
   logic signed [lst_pkg::KEY_W-1:0] lt_x;
   logic [lst_pkg::SUM_W-1:0]      leaf_val;
   logic signed [lst_pkg::KEY_W-1:0] leaf_x;
   logic                           go_left;
   logic                           leaf_nf;

   // shared arithmetic: level sizes, overlap count, child totals
   always_comb begin
      half      = lst_pkg::NODE_W'(1) << (lvl_ff - lst_pkg::LVL_W'(1));
      span      = lst_pkg::NODE_W'(1) << lvl_ff;
      p_off     = p_ff - a_ff;
      cnt       = lst_pkg::CNT_W'(p_off) + lst_pkg::CNT_W'(1);
      prod_full = v_ff * cnt;
      acc_tu    = acc_ff + tu_ff;
      lt        = rd_data.sum + (acc_tu << (lvl_ff - lst_pkg::LVL_W'(1)));
      lt_x      = {{SX_W{lt[lst_pkg::SUM_W-1]}}, lt};
      leaf_val  = cs_ff + acc_ff;
      leaf_x    = {{SX_W{leaf_val[lst_pkg::SUM_W-1]}}, leaf_val};
      if (op_ff == lst_pkg::OP_FIRST) begin
         go_left = (lt != '0);
         leaf_nf = (leaf_val == '0);
      end else begin
         go_left = (lt_x >= k_ff);
         leaf_nf = (leaf_x < k_ff);
      end
   end

   // state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lst_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      u_ff    <= u_in;
      a_ff    <= a_in;
      lvl_ff  <= lvl_in;
      acc_ff  <= acc_in;
      tu_ff   <= tu_in;
      cs_ff   <= cs_in;
      k_ff    <= k_in;
      op_ff   <= op_in;
      p_ff    <= p_in;
      lo_ff   <= lo_in;
      v_ff    <= v_in;
      pass_ff <= pass_in;
      prod_ff <= prod_in;
   end

   // sequencer: next state, memory beats and result
   always_comb begin
      state_in = state_ff;
      u_in     = u_ff;
      a_in     = a_ff;
      lvl_in   = lvl_ff;
      acc_in   = acc_ff;
      tu_in    = tu_ff;
      cs_in    = cs_ff;
      k_in     = k_ff;
      op_in    = op_ff;
      p_in     = p_ff;
      lo_in    = lo_ff;
      v_in     = v_ff;
      pass_in  = pass_ff;
      prod_in  = prod_ff;
      clr_in   = clr_ff;
      ram_req  = '0;
      result   = '0;
      req.ready = 1'b0;

      unique case (state_ff)
         lst_pkg::ST_CLEAR: begin
            // write the reset tree: the leftmost path holds one
            ram_req.wr_en       = 1'b1;
            ram_req.wr_addr     = clr_ff;
            ram_req.wr_data.sum = (clr_ff <= lst_pkg::NODE_W'(lst_pkg::TREE_LEVELS)) ?
                                  lst_pkg::SUM_W'(1) : '0;
            ram_req.wr_data.tag = '0;
            clr_in = clr_ff + lst_pkg::NODE_W'(1);
            if (clr_ff == lst_pkg::NODE_W'(lst_pkg::NODES - 1)) begin
               state_in = lst_pkg::ST_IDLE;
            end
         end

         lst_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            u_in   = '0;
            a_in   = '0;
            lvl_in = lst_pkg::LVL_W'(lst_pkg::TREE_LEVELS);
            acc_in = '0;
            op_in  = req.opcode;
            if (req.valid) begin
               unique case (req.opcode)
                  lst_pkg::OP_ADD: begin
                     // range add is two prefix adds: +v up to high, -v below low
                     p_in    = req.range_high;
                     lo_in   = req.range_low;
                     v_in    = lst_pkg::SUM_W'(req.add_value);
                     pass_in = 1'b0;
                     if (req.range_low <= req.range_high) begin
                        state_in = lst_pkg::ST_ADD_RD;
                     end
                  end
                  lst_pkg::OP_FIRST, lst_pkg::OP_RANK: begin
                     k_in     = lst_pkg::KEY_W'(req.rank);
                     state_in = lst_pkg::ST_Q_ROOT;
                  end
                  default: begin
                     state_in = lst_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         lst_pkg::ST_ADD_RD: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = u_ff;
            prod_in  = prod_full[lst_pkg::SUM_W-1:0];
            state_in = lst_pkg::ST_ADD_WR;
         end

         lst_pkg::ST_ADD_WR: begin
            // node on the path gains v times its overlap with the prefix
            ram_req.wr_en       = 1'b1;
            ram_req.wr_addr     = u_ff;
            ram_req.wr_data.sum = rd_data.sum + prod_ff;
            ram_req.wr_data.tag = rd_data.tag;
            if (lvl_ff == '0) begin
               if (!pass_ff && lo_ff != '0) begin
                  pass_in  = 1'b1;
                  p_in     = lo_ff - lst_pkg::POS_W'(1);
                  v_in     = '0 - v_ff;
                  u_in     = '0;
                  a_in     = '0;
                  lvl_in   = lst_pkg::LVL_W'(lst_pkg::TREE_LEVELS);
                  state_in = lst_pkg::ST_ADD_RD;
               end else begin
                  state_in = lst_pkg::ST_IDLE;
               end
            end else if (lst_pkg::NODE_W'(p_off) < half) begin
               u_in     = u_ff + lst_pkg::NODE_W'(1);
               lvl_in   = lvl_ff - lst_pkg::LVL_W'(1);
               state_in = lst_pkg::ST_ADD_RD;
            end else begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = u_ff + lst_pkg::NODE_W'(1);
               state_in        = lst_pkg::ST_ADD_LEFT;
            end
         end

         lst_pkg::ST_ADD_LEFT: begin
            // left child lies wholly inside the prefix: tag it
            ram_req.wr_en       = 1'b1;
            ram_req.wr_addr     = u_ff + lst_pkg::NODE_W'(1);
            ram_req.wr_data.sum = rd_data.sum + (v_ff << (lvl_ff - lst_pkg::LVL_W'(1)));
            ram_req.wr_data.tag = rd_data.tag + v_ff;
            u_in     = u_ff + span;
            a_in     = a_ff + lst_pkg::POS_W'(half);
            lvl_in   = lvl_ff - lst_pkg::LVL_W'(1);
            state_in = lst_pkg::ST_ADD_RD;
         end

         lst_pkg::ST_Q_ROOT: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = u_ff;
            state_in        = lst_pkg::ST_Q_ROOT_D;
         end

         lst_pkg::ST_Q_ROOT_D: begin
            tu_in    = rd_data.tag;
            cs_in    = rd_data.sum;
            state_in = lst_pkg::ST_Q_LEFT;
         end

         lst_pkg::ST_Q_LEFT: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = u_ff + lst_pkg::NODE_W'(1);
            state_in        = lst_pkg::ST_Q_LEFT_D;
         end

         lst_pkg::ST_Q_LEFT_D: begin
            // choose a half from the left child's true total
            acc_in = acc_tu;
            lvl_in = lvl_ff - lst_pkg::LVL_W'(1);
            if (go_left) begin
               u_in     = u_ff + lst_pkg::NODE_W'(1);
               tu_in    = rd_data.tag;
               cs_in    = rd_data.sum;
               state_in = (lvl_ff == lst_pkg::LVL_W'(1)) ? lst_pkg::ST_Q_DONE :
                                                           lst_pkg::ST_Q_LEFT;
            end else begin
               k_in            = k_ff - lt_x;
               u_in            = u_ff + span;
               a_in            = a_ff + lst_pkg::POS_W'(half);
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = u_ff + span;
               state_in        = lst_pkg::ST_Q_RIGHT_D;
            end
         end

         lst_pkg::ST_Q_RIGHT_D: begin
            tu_in    = rd_data.tag;
            cs_in    = rd_data.sum;
            state_in = (lvl_ff == '0) ? lst_pkg::ST_Q_DONE : lst_pkg::ST_Q_LEFT;
         end

         lst_pkg::ST_Q_DONE: begin
            // hold the leaf result until the output register frees
            if (out_free) begin
               result.valid     = 1'b1;
               result.position  = a_ff;
               result.not_found = leaf_nf;
               state_in         = lst_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lst_pkg::ST_IDLE;
         end
      endcase
   end

   assign status.busy     = (state_ff != lst_pkg::ST_IDLE);
   assign status.clearing = (state_ff == lst_pkg::ST_CLEAR);

endmodule

/* rtl/lazy_segment_tree_range_add_kth_unit.sv */
// Top level of the segment tree range-add and position search unit.
//
//   channel  | dir | beat contents
//   ---------+-----+----------------------------------------------
//   req_bus  | in  | opcode, range_low, range_high, add_value, rank
//   rsp_bus  | out | position, not_found (searches only)
//
// A range add is one prefix descent when low is zero and two otherwise, each over the 10
// levels of the tree down to a leaf. A search is accepted, reads the root, then descends
// level by level to a leaf, and waits there while the output register stays full.
// After reset a clearing pass writes all 2048 nodes, with req not ready.
// The result sits in an output register; a new request is taken while it waits.
module lazy_segment_tree_range_add_kth_unit (
   input  logic      clock,
   input  logic      reset,
   lst_req_if.sink   req_bus,
   lst_rsp_if.source rsp_bus
);

   lst_pkg::ram_req_type ram_req;
   lst_pkg::node_type    rd_data;
   lst_pkg::result_type  result;
   lst_pkg::status_type  status;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [lst_pkg::POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic                      rsp_nf_ff, rsp_nf_in;
   logic                      out_free;

   lst_node_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   lst_walker u_walker (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .out_free (out_free),
      .rd_data  (rd_data),
      .ram_req  (ram_req),
      .result   (result),
      .status   (status)
   );

   // output register: load a finished result, drop it once taken
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_nf_in    = rsp_nf_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         rsp_pos_in   = result.position;
         rsp_nf_in    = result.not_found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pos_ff <= rsp_pos_in;
      rsp_nf_ff  <= rsp_nf_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.position  = rsp_pos_ff;
   assign rsp_bus.not_found = rsp_nf_ff;

`ifndef ASSERT_OFF
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !req_bus.ready)
      else $error("request taken during clearing pass");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready &&
       (req_bus.opcode == lst_pkg::OP_FIRST || req_bus.opcode == lst_pkg::OP_RANK))
      |=> status.busy)
      else $error("search did not start after accept");

   a_result_needs_room: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> out_free)
      else $error("result issued while output register full");
`endif

endmodule
